// ===== sv/hrc_pkg.sv =====
package hrc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_FROM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_TO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLACKOUT    = 3'd4;

    // Restoring divider geometry, shared by the three reverse quotients
    localparam int REM_W  = 19;
    localparam int DEN_W  = 10;
    localparam int QUO_W  = 9;
    localparam int N_DIV  = 3;
    localparam int DIV_LVL = 0;
    localparam int DIV_SAT = 1;
    localparam int DIV_HUE = 2;

    // Colour component order in arrays
    localparam int COL_R = 0;
    localparam int COL_G = 1;
    localparam int COL_B = 2;

    // Reciprocal for divide by 100 (shift 19) and by 25 (shift 17)
    localparam logic [12:0] RECIP = 13'd5243;

    typedef struct packed {
        logic       enabled;
        logic [7:0] dim_from;
        logic [7:0] dim_to;
        logic [8:0] master_gain;
        logic       blackout;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic       power_on;
        logic [6:0] brightness;
        logic [8:0] hue_deg;
        logic [6:0] saturation_pct;
        logic [7:0] dmx_dimmer;
        logic [7:0] dmx_red;
        logic [7:0] dmx_green;
        logic [7:0] dmx_blue;
        logic [7:0] dmx_white;
    } in_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] out_dimmer;
        logic [7:0] out_dimmer_wire;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_white;
        logic       lit;
        logic [6:0] level_reading;
        logic [6:0] sat_reading;
        logic [8:0] hue_reading;
        logic       hue_valid;
    } out_t;

    // Pipeline payload, the same word in every stage
    typedef struct packed {
        logic                         op;
        logic                         power;
        logic [6:0]                   bri;
        logic [6:0]                   sat;
        logic [10:0]                  sat17;
        logic [2:0][5:0]              comp;
        logic signed [8:0]            diff;
        logic [14:0]                  mag;
        logic                         neg;
        logic [2:0][16:0]             nc;
        logic [14:0]                  nw;
        logic [7:0]                   qd;
        logic [2:0][7:0]              cq;
        logic [7:0]                   wq;
        logic [7:0]                   dim;
        logic [17:0]                  wprod;
        logic [7:0]                   rdim;
        logic [7:0]                   rw;
        logic [7:0]                   peak;
        logic [7:0]                   delta;
        logic [10:0]                  hs;
        logic                         lit;
        logic                         full;
        logic [N_DIV-1:0][REM_W-1:0]  rem;
        logic [N_DIV-1:0][DEN_W-1:0]  den;
        logic [N_DIV-1:0][QUO_W-1:0]  quo;
    } pl_t;

endpackage

// ===== sv/hrc_front.sv =====
module hrc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  hrc_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  hrc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hrc_pkg::pl_t   out_pl
);
    import hrc_pkg::*;

    localparam int NS = 5;
    localparam logic [9:0] HUE_OFS [3] = '{10'd300, 10'd180, 10'd60};

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] src_v;
    pl_t           pl_reg  [NS];
    pl_t           pl_next [NS];

    logic [9:0]  hue_a [3];
    logic [8:0]  hue_k [3];
    logic [5:0]  dip   [3];
    logic [6:0]  bri0;
    logic [6:0]  sat0;
    logic [7:0]  r0, g0, b0, base0;
    logic signed [16:0] v1;
    logic [16:0] av1;
    logic [7:0]  span1;
    logic [8:0]  d1;
    logic [27:0] tq2;
    logic [27:0] tw2;
    logic [25:0] tc2 [3];
    logic [7:0]  dd4;

    // Per-stage handshake: a stage loads when it is empty or its successor moves
    assign rdy[NS] = out_ready;
    for (genvar i = 0; i < NS; i++) begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end
    assign src_v    = {v_reg[NS-2:0], in_valid};
    assign in_ready = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_pl    = pl_reg[NS-1];

    // Stage 0: clamp, hue sector weights, peak and hue numerator seed
    always_comb begin
        pl_next[0] = '0;
        pl_next[0].op    = in_data.op;
        pl_next[0].power = in_data.power_on;
        bri0 = in_data.brightness;
        if (bri0 == 7'd0) bri0 = 7'd1;
        if (bri0 > 7'd100) bri0 = 7'd100;
        sat0 = (in_data.saturation_pct > 7'd100) ? 7'd100 : in_data.saturation_pct;
        pl_next[0].bri   = bri0;
        pl_next[0].sat   = sat0;
        pl_next[0].sat17 = 11'({sat0, 4'b0000}) + 11'(sat0);
        for (int j = 0; j < 3; j++) begin
            hue_a[j] = 10'(in_data.hue_deg) + HUE_OFS[j];
            if (hue_a[j] >= 10'd720)      hue_k[j] = 9'(hue_a[j] - 10'd720);
            else if (hue_a[j] >= 10'd360) hue_k[j] = 9'(hue_a[j] - 10'd360);
            else                          hue_k[j] = 9'(hue_a[j]);
            if (hue_k[j] <= 9'd60)       dip[j] = 6'(hue_k[j]);
            else if (hue_k[j] <= 9'd180) dip[j] = 6'd60;
            else if (hue_k[j] < 9'd240)  dip[j] = 6'(9'd240 - hue_k[j]);
            else                         dip[j] = 6'd0;
            pl_next[0].comp[j] = 6'd60 - dip[j];
        end
        pl_next[0].diff = $signed({1'b0, cfg.dim_to}) - $signed({1'b0, cfg.dim_from});

        r0 = in_data.dmx_red;
        g0 = in_data.dmx_green;
        b0 = in_data.dmx_blue;
        pl_next[0].peak = r0;
        if (g0 > pl_next[0].peak) pl_next[0].peak = g0;
        if (b0 > pl_next[0].peak) pl_next[0].peak = b0;
        base0 = r0;
        if (g0 < base0) base0 = g0;
        if (b0 < base0) base0 = b0;
        pl_next[0].delta = pl_next[0].peak - base0;
        // Red wins a tie for the peak, then green
        if (pl_next[0].peak == r0) begin
            if (g0 >= b0) pl_next[0].hs = 11'(g0 - b0);
            else          pl_next[0].hs = 11'(pl_next[0].delta) * 11'd6 - 11'(b0 - g0);
        end else if (pl_next[0].peak == g0) begin
            pl_next[0].hs = 11'(b0) + 11'({pl_next[0].delta, 1'b0}) - 11'(r0);
        end else begin
            pl_next[0].hs = 11'(r0) + 11'({pl_next[0].delta, 2'b00}) - 11'(g0);
        end
        pl_next[0].rdim = in_data.dmx_dimmer;
        pl_next[0].rw   = in_data.dmx_white;
        pl_next[0].lit  = in_data.dmx_dimmer >= cfg.dim_from;
        pl_next[0].full = (in_data.dmx_dimmer > cfg.dim_to) || (cfg.dim_to <= cfg.dim_from);
    end

    // Stage 1: products and divider operands
    always_comb begin
        pl_next[1] = pl_reg[0];
        v1  = pl_reg[0].diff * $signed({1'b0, pl_reg[0].bri});
        av1 = (v1 < 0) ? 17'(-v1) : 17'(v1);
        pl_next[1].mag = 15'(av1) + 15'd50;
        pl_next[1].neg = v1 < 0;
        for (int j = 0; j < 3; j++) begin
            pl_next[1].nc[j] = 17'(pl_reg[0].sat17 * pl_reg[0].comp[j]) + 17'd200;
        end
        pl_next[1].nw = 15'(8'd255 * (7'd100 - pl_reg[0].sat)) + 15'd50;

        span1 = cfg.dim_to - cfg.dim_from;
        if (pl_reg[0].lit && !pl_reg[0].full) begin
            pl_next[1].rem[DIV_LVL] = 19'((pl_reg[0].rdim - cfg.dim_from) * 8'd200)
                                      + 19'(span1);
            pl_next[1].den[DIV_LVL] = 10'({span1, 1'b0});
        end else begin
            pl_next[1].rem[DIV_LVL] = '0;
            pl_next[1].den[DIV_LVL] = 10'd1;
        end
        d1 = 9'(pl_reg[0].peak) + 9'(pl_reg[0].rw);
        if (d1 != 9'd0) begin
            pl_next[1].rem[DIV_SAT] = 19'(pl_reg[0].peak * 8'd200) + 19'(d1);
            pl_next[1].den[DIV_SAT] = {d1, 1'b0};
        end else begin
            pl_next[1].rem[DIV_SAT] = '0;
            pl_next[1].den[DIV_SAT] = 10'd1;
        end
        if (pl_reg[0].delta != 8'd0) begin
            pl_next[1].rem[DIV_HUE] = 19'(pl_reg[0].hs * 7'd120) + 19'(pl_reg[0].delta);
            pl_next[1].den[DIV_HUE] = 10'({pl_reg[0].delta, 1'b0});
        end else begin
            pl_next[1].rem[DIV_HUE] = '0;
            pl_next[1].den[DIV_HUE] = 10'd1;
        end
        pl_next[1].quo = '0;
    end

    // Stage 2: constant divides by reciprocal multiply
    always_comb begin
        pl_next[2] = pl_reg[1];
        tq2 = pl_reg[1].mag * RECIP;
        pl_next[2].qd = tq2[26:19];
        tw2 = pl_reg[1].nw * RECIP;
        pl_next[2].wq = tw2[26:19];
        for (int j = 0; j < 3; j++) begin
            tc2[j] = pl_reg[1].nc[j][16:4] * RECIP;
            pl_next[2].cq[j] = tc2[j][24:17];
        end
    end

    // Stage 3: dimmer byte
    always_comb begin
        pl_next[3] = pl_reg[2];
        if (!pl_reg[2].power)   pl_next[3].dim = 8'd0;
        else if (pl_reg[2].neg) pl_next[3].dim = cfg.dim_from - pl_reg[2].qd;
        else                    pl_next[3].dim = cfg.dim_from + pl_reg[2].qd;
    end

    // Stage 4: master gain product
    always_comb begin
        pl_next[4] = pl_reg[3];
        dd4 = pl_reg[3].dim - cfg.dim_from;
        pl_next[4].wprod = 18'(dd4 * cfg.master_gain) + 18'd128;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (rdy[i]) v_reg[i] <= src_v[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NS; i++) begin
            if (rdy[i] && src_v[i]) pl_reg[i] <= pl_next[i];
        end
    end

endmodule

// ===== sv/hrc_div_step.sv =====
module hrc_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [3:0]    shift_amt,
    input  logic          in_valid,
    output logic          in_ready,
    input  hrc_pkg::pl_t  in_pl,
    output logic          out_valid,
    input  logic          out_ready,
    output hrc_pkg::pl_t  out_pl
);
    import hrc_pkg::*;

    logic             v_reg;
    pl_t              pl_reg;
    pl_t              pl_next;
    logic [REM_W-1:0] trial [N_DIV];

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_pl    = pl_reg;

    // One restoring quotient bit for each of the three divides
    always_comb begin
        pl_next = in_pl;
        for (int j = 0; j < N_DIV; j++) begin
            trial[j] = REM_W'(in_pl.den[j]) << shift_amt;
            if (in_pl.rem[j] >= trial[j]) begin
                pl_next.rem[j] = in_pl.rem[j] - trial[j];
                pl_next.quo[j][shift_amt] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) pl_reg <= pl_next;
    end

endmodule

// ===== sv/hrc_back.sv =====
module hrc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  hrc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  hrc_pkg::pl_t  in_pl,
    output logic          out_valid,
    input  logic          out_ready,
    output hrc_pkg::out_t out_data
);
    import hrc_pkg::*;

    logic       v_reg;
    out_t       out_reg;
    out_t       out_next;
    logic [7:0] wire_dim;
    logic [6:0] lvl_q;
    logic [8:0] hue_q;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = out_reg;

    // Wire dimmer after blackout and master gain
    always_comb begin
        if (cfg.blackout || cfg.master_gain == 9'd0) wire_dim = 8'd0;
        else if (cfg.master_gain[8])                 wire_dim = in_pl.dim;
        else if (in_pl.dim < cfg.dim_from)           wire_dim = in_pl.dim;
        else                                         wire_dim = cfg.dim_from + in_pl.wprod[15:8];
    end

    // Select the direction, drop everything when not enabled
    always_comb begin
        out_next = '0;
        lvl_q = in_pl.quo[DIV_LVL][6:0];
        hue_q = in_pl.quo[DIV_HUE];
        if (cfg.enabled) begin
            out_next.accepted = 1'b1;
            if (!in_pl.op) begin
                out_next.out_dimmer      = in_pl.dim;
                out_next.out_dimmer_wire = wire_dim;
                out_next.out_red         = in_pl.cq[COL_R];
                out_next.out_green       = in_pl.cq[COL_G];
                out_next.out_blue        = in_pl.cq[COL_B];
                out_next.out_white       = in_pl.wq;
            end else begin
                out_next.lit = in_pl.lit;
                if (in_pl.lit) begin
                    if (in_pl.full)          out_next.level_reading = 7'd100;
                    else if (lvl_q == 7'd0)  out_next.level_reading = 7'd1;
                    else                     out_next.level_reading = lvl_q;
                end
                out_next.sat_reading = in_pl.quo[DIV_SAT][6:0];
                out_next.hue_reading = (hue_q >= 9'd360) ? hue_q - 9'd360 : hue_q;
                out_next.hue_valid   = in_pl.peak != 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) out_reg <= out_next;
    end

endmodule

// ===== sv/hsv_rgbw_colour_converter.sv =====
// Pipeline from request to result: 5 front stages, 9 divider steps, 1 output stage.
// Throughput: one request per cycle; each stage stalls independently on backpressure.
// The depth is set by the 9-bit restoring divide, one quotient bit per stage.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults: disabled, dim_from 0, dim_to 255, master_gain 256, blackout off.
module hsv_rgbw_colour_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hrc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [hrc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // power_on, brightness, hue_deg, saturation_pct, dmx_dimmer, dmx_red,
    // dmx_green, dmx_blue, dmx_white
    input  logic [63:0]                   s_tdata,
    // op
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_dimmer, out_dimmer_wire, out_red, out_green, out_blue, out_white,
    // lit, level_reading, sat_reading, hue_reading, hue_valid, zero fill
    output logic [79:0]                   m_tdata,
    // accepted
    output logic [0:0]                    m_tuser
);
    import hrc_pkg::*;

    localparam int NDS = QUO_W;

    cfg_t cfg_reg;
    in_t  in_data;
    out_t out_data;

    logic          f_valid, f_ready;
    pl_t           f_pl;
    logic [NDS:0]  d_valid;
    logic [NDS:0]  d_ready;
    pl_t           d_pl [NDS+1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled     <= 1'b0;
            cfg_reg.dim_from    <= 8'd0;
            cfg_reg.dim_to      <= 8'd255;
            cfg_reg.master_gain <= 9'd256;
            cfg_reg.blackout    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ENABLED:     cfg_reg.enabled     <= cfg_wr_data[0];
                REG_DIM_FROM:    cfg_reg.dim_from    <= cfg_wr_data[7:0];
                REG_DIM_TO:      cfg_reg.dim_to      <= cfg_wr_data[7:0];
                REG_MASTER_GAIN: cfg_reg.master_gain <= cfg_wr_data;
                REG_BLACKOUT:    cfg_reg.blackout    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Unpack the request
    assign in_data.op             = s_tuser[0];
    assign in_data.power_on       = s_tdata[0];
    assign in_data.brightness     = s_tdata[7:1];
    assign in_data.hue_deg        = s_tdata[16:8];
    assign in_data.saturation_pct = s_tdata[23:17];
    assign in_data.dmx_dimmer     = s_tdata[31:24];
    assign in_data.dmx_red        = s_tdata[39:32];
    assign in_data.dmx_green      = s_tdata[47:40];
    assign in_data.dmx_blue       = s_tdata[55:48];
    assign in_data.dmx_white      = s_tdata[63:56];

    hrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_pl    (f_pl)
    );

    assign d_valid[0] = f_valid;
    assign f_ready    = d_ready[0];
    assign d_pl[0]    = f_pl;

    // Divider chain, most significant quotient bit first
    for (genvar i = 0; i < NDS; i++) begin : g_div
        hrc_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_amt (4'(NDS - 1 - i)),
            .in_valid  (d_valid[i]),
            .in_ready  (d_ready[i]),
            .in_pl     (d_pl[i]),
            .out_valid (d_valid[i+1]),
            .out_ready (d_ready[i+1]),
            .out_pl    (d_pl[i+1])
        );
    end

    hrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (d_valid[NDS]),
        .in_ready  (d_ready[NDS]),
        .in_pl     (d_pl[NDS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result
    assign m_tuser[0]     = out_data.accepted;
    assign m_tdata[7:0]   = out_data.out_dimmer;
    assign m_tdata[15:8]  = out_data.out_dimmer_wire;
    assign m_tdata[23:16] = out_data.out_red;
    assign m_tdata[31:24] = out_data.out_green;
    assign m_tdata[39:32] = out_data.out_blue;
    assign m_tdata[47:40] = out_data.out_white;
    assign m_tdata[48]    = out_data.lit;
    assign m_tdata[55:49] = out_data.level_reading;
    assign m_tdata[62:56] = out_data.sat_reading;
    assign m_tdata[71:63] = out_data.hue_reading;
    assign m_tdata[72]    = out_data.hue_valid;
    assign m_tdata[79:73] = '0;

    // A disabled block returns an all-zero result
    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !cfg_reg.enabled |-> m_tuser == 1'b0 && m_tdata == '0)
        else $error("result not cleared while disabled");

    // An unlit reverse result carries no level
    a_unlit_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_data.lit |-> out_data.level_reading == 7'd0)
        else $error("level reading without lit");

    // Hue wraps below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_data.hue_reading < 9'd360)
        else $error("hue reading out of range");

    // Forward and reverse fields never mix in one result
    a_dir_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_data.out_white != 8'd0) |->
            !out_data.lit && !out_data.hue_valid && out_data.sat_reading == 7'd0)
        else $error("forward and reverse fields mixed");

endmodule
